FILE: rtl/ptps_pkg.sv
`default_nettype none

package ptps_pkg;

   localparam int SLOTS       = 16;
   localparam int MAX_RESULTS = 16;
   localparam int ADDR_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = $clog2(SLOTS + 1);
   localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);
   localparam int PERIOD_W    = 16;
   localparam int TIME_W      = 32;
   localparam int STEP_W      = $clog2(PERIOD_W);

   localparam logic [15:0] TPS_RESET = 16'd1000;

   typedef logic [ADDR_W-1:0]   slot_addr_type;
   typedef logic [CNT_W-1:0]    slot_cnt_type;
   typedef logic [FIRE_W-1:0]   fire_cnt_type;
   typedef logic [STEP_W-1:0]   div_step_type;
   typedef logic [PERIOD_W-1:0] period_type;
   typedef logic [TIME_W-1:0]   time_type;

   typedef enum logic [2:0] {
      REQ_CREATE  = 3'd0,
      REQ_START   = 3'd1,
      REQ_STOP    = 3'd2,
      REQ_SETFREQ = 3'd3,
      REQ_RUN     = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_CREATE = 2'd0,
      KIND_FIRE   = 2'd1,
      KIND_IDLE   = 2'd2
   } rsp_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_WRITE,
      ST_REPLY,
      ST_SCAN,
      ST_SCAN_END
   } state_type;

   typedef struct packed {
      logic       enabled;
      period_type period;
      time_type   last_run;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

FILE: rtl/ptps_ram.sv
`default_nettype none

module ptps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/periodic_task_poll_scheduler_core.sv
`default_nettype none

// Periodic polling task scheduler. Slot state (started flag, period, last-run
// time) lives in one single-port-read RAM with a registered read; start, stop
// and set frequency are read-modify-writes of that RAM, and requests are taken
// one at a time. Create and set frequency compute the period with a 16-step
// restoring divider (one quotient bit per cycle); with a zero frequency the
// divider is skipped, as it is for a create on a full table. A run scan reads
// one slot per cycle, while the result side does not stall it, through a
// two-stage read/evaluate pipeline. Back-pressure on the result side holds
// off result beats. The RAM needs no clearing after reset: only created slots
// are ever read. Configuration writes are always taken.

module periodic_task_poll_scheduler_core (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [3:0] task_slot, [19:4] freq_hz, [20] start_now, [52:21] now_ms
   input  wire logic [55:0] req_tdata,
   // [2:0] req_type
   input  wire logic [2:0]  req_tuser,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] slot_index, [4] create_ok
   output logic [7:0]       rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   ptps_pkg::state_type     state_ff, state_in;
   ptps_pkg::req_kind_type  op_ff, op_in;
   logic [3:0]              slot_ff, slot_in;
   ptps_pkg::period_type    freq_ff, freq_in;
   logic                    start_ff, start_in;
   ptps_pkg::time_type      now_ff, now_in;
   logic [15:0]             tps_ff, tps_in;
   ptps_pkg::slot_cnt_type  count_ff, count_in;

   ptps_pkg::period_type    div_rem_ff, div_rem_in;
   ptps_pkg::period_type    div_quo_ff, div_quo_in;
   ptps_pkg::div_step_type  div_step_ff, div_step_in;

   ptps_pkg::slot_cnt_type  rd_idx_ff, rd_idx_in;
   logic                    ev_vld_ff, ev_vld_in;
   ptps_pkg::slot_addr_type ev_idx_ff, ev_idx_in;
   logic                    pend_vld_ff, pend_vld_in;
   ptps_pkg::slot_addr_type pend_idx_ff, pend_idx_in;
   ptps_pkg::fire_cnt_type  fire_cnt_ff, fire_cnt_in;

   logic                    rsp_vld_ff, rsp_vld_in;
   ptps_pkg::rsp_kind_type  rsp_kind_ff, rsp_kind_in;
   logic [3:0]              rsp_slot_ff, rsp_slot_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    ram_wr_en;
   ptps_pkg::slot_addr_type ram_wr_addr;
   ptps_pkg::entry_type     ram_wr_data;
   logic                    ram_rd_en;
   ptps_pkg::slot_addr_type ram_rd_addr;
   logic [ptps_pkg::ENTRY_W-1:0] ram_rd_bits;
   ptps_pkg::entry_type     ent;

   ptps_pkg::req_kind_type  in_kind;
   logic [3:0]              in_slot;
   ptps_pkg::period_type    in_freq;
   logic                    in_start;
   ptps_pkg::time_type      in_now;

   logic                    req_acc;
   logic                    out_free;
   logic                    slot_ok;
   logic                    room;
   logic [16:0]             rem_sh;
   logic                    rem_ge;
   logic                    div_last;
   ptps_pkg::time_type      elapsed;
   logic                    due;
   logic                    report;
   logic                    stall;
   logic                    advance;
   logic                    rd_more;
   logic                    scan_done;

   ptps_ram #(
      .WIDTH (ptps_pkg::ENTRY_W),
      .DEPTH (ptps_pkg::SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ent       = ptps_pkg::entry_type'(ram_rd_bits);

   assign in_kind   = ptps_pkg::req_kind_type'(req_tuser);
   assign in_slot   = req_tdata[3:0];
   assign in_freq   = req_tdata[19:4];
   assign in_start  = req_tdata[20];
   assign in_now    = req_tdata[52:21];

   assign req_tready = (state_ff == ptps_pkg::ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = ~rsp_vld_ff | rsp_tready;

   assign slot_ok = (32'(in_slot) < 32'(count_ff));
   assign room    = (count_ff < ptps_pkg::slot_cnt_type'(ptps_pkg::SLOTS));

   assign rem_sh   = {div_rem_ff, div_quo_ff[15]};
   assign rem_ge   = (rem_sh >= {1'b0, freq_ff});
   assign div_last = (div_step_ff == ptps_pkg::div_step_type'(ptps_pkg::PERIOD_W - 1));

   assign elapsed   = now_ff - ent.last_run;
   assign due       = ev_vld_ff & ent.enabled & (elapsed >= 32'(ent.period));
   assign report    = due & (fire_cnt_ff < ptps_pkg::fire_cnt_type'(ptps_pkg::MAX_RESULTS));
   assign stall     = report & pend_vld_ff & ~out_free;
   assign advance   = ~stall;
   assign rd_more   = (rd_idx_ff < count_ff);
   assign scan_done = ~rd_more & ~ev_vld_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptps_pkg::ST_IDLE: begin
            if (req_acc) begin
               unique case (in_kind)
                  ptps_pkg::REQ_CREATE: begin
                     state_in = (room && in_freq != '0) ? ptps_pkg::ST_DIV
                                                        : ptps_pkg::ST_REPLY;
                  end
                  ptps_pkg::REQ_START,
                  ptps_pkg::REQ_STOP: begin
                     state_in = slot_ok ? ptps_pkg::ST_READ : ptps_pkg::ST_IDLE;
                  end
                  ptps_pkg::REQ_SETFREQ: begin
                     if (!slot_ok) begin
                        state_in = ptps_pkg::ST_IDLE;
                     end else if (in_freq != '0) begin
                        state_in = ptps_pkg::ST_DIV;
                     end else begin
                        state_in = ptps_pkg::ST_READ;
                     end
                  end
                  ptps_pkg::REQ_RUN: begin
                     state_in = ptps_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = ptps_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         ptps_pkg::ST_DIV: begin
            if (div_last) begin
               state_in = (op_ff == ptps_pkg::REQ_CREATE) ? ptps_pkg::ST_REPLY
                                                          : ptps_pkg::ST_READ;
            end
         end
         ptps_pkg::ST_READ: begin
            state_in = ptps_pkg::ST_WRITE;
         end
         ptps_pkg::ST_WRITE: begin
            state_in = ptps_pkg::ST_IDLE;
         end
         ptps_pkg::ST_REPLY: begin
            if (out_free) begin
               state_in = ptps_pkg::ST_IDLE;
            end
         end
         ptps_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = ptps_pkg::ST_SCAN_END;
            end
         end
         ptps_pkg::ST_SCAN_END: begin
            if (out_free) begin
               state_in = ptps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptps_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath, RAM access and result beats
   always_comb begin
      op_in       = op_ff;
      slot_in     = slot_ff;
      freq_in     = freq_ff;
      start_in    = start_ff;
      now_in      = now_ff;
      count_in    = count_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_step_in = div_step_ff;
      rd_idx_in   = rd_idx_ff;
      ev_vld_in   = ev_vld_ff;
      ev_idx_in   = ev_idx_ff;
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;
      fire_cnt_in = fire_cnt_ff;

      rsp_vld_in  = rsp_vld_ff & ~rsp_tready;
      rsp_kind_in = rsp_kind_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_ok_in   = rsp_ok_ff;
      rsp_last_in = rsp_last_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = ev_idx_ff;
      ram_wr_data = ent;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff[ptps_pkg::ADDR_W-1:0];

      tps_in = csr_valid ? csr_data : tps_ff;

      unique case (state_ff)
         ptps_pkg::ST_IDLE: begin
            if (req_acc) begin
               op_in       = in_kind;
               slot_in     = in_slot;
               freq_in     = in_freq;
               start_in    = in_start;
               now_in      = in_now;
               div_rem_in  = '0;
               div_quo_in  = (in_freq == '0) ? '0 : tps_ff;
               div_step_in = '0;
               rd_idx_in   = '0;
               ev_vld_in   = 1'b0;
               pend_vld_in = 1'b0;
               fire_cnt_in = '0;
            end
         end
         ptps_pkg::ST_DIV: begin
            div_step_in = div_step_ff + 1'b1;
            div_quo_in  = {div_quo_ff[14:0], rem_ge};
            div_rem_in  = rem_ge ? 16'(rem_sh - {1'b0, freq_ff}) : rem_sh[15:0];
         end
         ptps_pkg::ST_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptps_pkg::slot_addr_type'(slot_ff);
         end
         ptps_pkg::ST_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptps_pkg::slot_addr_type'(slot_ff);
            unique case (op_ff)
               ptps_pkg::REQ_START:   ram_wr_data.enabled = 1'b1;
               ptps_pkg::REQ_STOP:    ram_wr_data.enabled = 1'b0;
               ptps_pkg::REQ_SETFREQ: ram_wr_data.period  = div_quo_ff;
               default:               ram_wr_data = ent;
            endcase
         end
         ptps_pkg::ST_REPLY: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_kind_in = ptps_pkg::KIND_CREATE;
               rsp_last_in = 1'b1;
               rsp_ok_in   = room;
               rsp_slot_in = room ? 4'(count_ff) : 4'd0;
               if (room) begin
                  ram_wr_en            = 1'b1;
                  ram_wr_addr          = count_ff[ptps_pkg::ADDR_W-1:0];
                  ram_wr_data.enabled  = start_ff;
                  ram_wr_data.period   = div_quo_ff;
                  ram_wr_data.last_run = '0;
                  count_in             = count_ff + 1'b1;
               end
            end
         end
         ptps_pkg::ST_SCAN: begin
            if (advance) begin
               ram_rd_en = rd_more;
               ev_vld_in = rd_more;
               ev_idx_in = rd_idx_ff[ptps_pkg::ADDR_W-1:0];
               if (rd_more) begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
               if (due) begin
                  ram_wr_en            = 1'b1;
                  ram_wr_addr          = ev_idx_ff;
                  ram_wr_data.last_run = now_ff;
               end
               if (report) begin
                  fire_cnt_in = fire_cnt_ff + 1'b1;
                  pend_vld_in = 1'b1;
                  pend_idx_in = ev_idx_ff;
                  if (pend_vld_ff) begin
                     rsp_vld_in  = 1'b1;
                     rsp_kind_in = ptps_pkg::KIND_FIRE;
                     rsp_slot_in = 4'(pend_idx_ff);
                     rsp_ok_in   = 1'b0;
                     rsp_last_in = 1'b0;
                  end
               end
            end
         end
         ptps_pkg::ST_SCAN_END: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_kind_in = pend_vld_ff ? ptps_pkg::KIND_FIRE : ptps_pkg::KIND_IDLE;
               rsp_slot_in = pend_vld_ff ? 4'(pend_idx_ff) : 4'd0;
               rsp_ok_in   = 1'b0;
               rsp_last_in = 1'b1;
            end
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ptps_pkg::ST_IDLE;
         tps_ff      <= ptps_pkg::TPS_RESET;
         count_ff    <= '0;
         ev_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tps_ff      <= tps_in;
         count_ff    <= count_in;
         ev_vld_ff   <= ev_vld_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      freq_ff     <= freq_in;
      start_ff    <= start_in;
      now_ff      <= now_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_step_ff <= div_step_in;
      rd_idx_ff   <= rd_idx_in;
      ev_idx_ff   <= ev_idx_in;
      pend_idx_ff <= pend_idx_in;
      fire_cnt_ff <= fire_cnt_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_ok_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
